[hdl/rmd_pkg.sv]
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths, status codes and the division stage record for the rescale
// multiply, divide and round unit.
// ----------------------------------------------------------------------------
package rmd_pkg;

   localparam int OperandWidth  = 63;
   localparam int QuotientWidth = 64;
   localparam int StatusWidth   = 2;
   localparam int HalfWidth     = 32;
   localparam int NumWidth      = 2 * OperandWidth;   // product plus rounding fits here
   localparam int DivSteps      = NumWidth;           // one numerator bit per stage

   localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_OVERFLOW = 2'd2;

   // One item in flight through the restoring divider.
   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic                     ovf;
      logic [OperandWidth-1:0]  divisor;
      logic [OperandWidth-1:0]  rem;
      logic [NumWidth-1:0]      num;
      logic [QuotientWidth-1:0] quo;
   } div_stage_type;

endpackage

[hdl/rmd_if.sv]
// ----------------------------------------------------------------------------
// rmd_req_if / rmd_rsp_if
// Valid and ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface rmd_req_if;
   logic                             valid;
   logic                             ready;
   logic [rmd_pkg::OperandWidth-1:0] multiplicand;
   logic [rmd_pkg::OperandWidth-1:0] multiplier;
   logic [rmd_pkg::OperandWidth-1:0] divisor;

   modport source (output valid, multiplicand, multiplier, divisor, input ready);
   modport sink   (input valid, multiplicand, multiplier, divisor, output ready);
endinterface

interface rmd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rmd_pkg::QuotientWidth-1:0] quotient;
   logic [rmd_pkg::StatusWidth-1:0]   status;

   modport source (output valid, quotient, status, input ready);
   modport sink   (input valid, quotient, status, output ready);
endinterface

[hdl/rmd_div_step.sv]
// ----------------------------------------------------------------------------
// rmd_div_step
// One registered step of the restoring divider: shifts in one numerator bit,
// subtracts the divisor when it fits and shifts in one quotient bit.
// ----------------------------------------------------------------------------
module rmd_div_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  rmd_pkg::div_stage_type stage_in,
   output rmd_pkg::div_stage_type stage_out
);

   rmd_pkg::div_stage_type stage_ff, stage_in_c;
   logic [rmd_pkg::OperandWidth:0] trial;
   logic [rmd_pkg::OperandWidth:0] diff;
   logic                           fits;

   always_comb begin
      trial = {stage_in.rem, stage_in.num[rmd_pkg::NumWidth-1]};
      fits  = trial >= {1'b0, stage_in.divisor};
      diff  = trial - {1'b0, stage_in.divisor};
      stage_in_c         = stage_in;
      stage_in_c.rem     = fits ? diff[rmd_pkg::OperandWidth-1:0]
                                : trial[rmd_pkg::OperandWidth-1:0];
      stage_in_c.num     = {stage_in.num[rmd_pkg::NumWidth-2:0], 1'b0};
      stage_in_c.quo     = {stage_in.quo[rmd_pkg::QuotientWidth-2:0], fits};
      // A quotient bit pushed past bit 63 means the result does not fit.
      stage_in_c.ovf     = stage_in.ovf | stage_in.quo[rmd_pkg::QuotientWidth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in_c.valid;
      end
      if (enable) begin
         stage_ff.zero    <= stage_in_c.zero;
         stage_ff.ovf     <= stage_in_c.ovf;
         stage_ff.divisor <= stage_in_c.divisor;
         stage_ff.rem     <= stage_in_c.rem;
         stage_ff.num     <= stage_in_c.num;
         stage_ff.quo     <= stage_in_c.quo;
      end
   end

   assign stage_out = stage_ff;

endmodule

[hdl/rescale_mul_div_round_unit.sv]
// ----------------------------------------------------------------------------
// rescale_mul_div_round_unit
// Computes multiplicand * multiplier / divisor rounded half up over the full
// product, flagging a zero divisor and a quotient wider than 64 bits.
// ----------------------------------------------------------------------------
//
//   channel   direction   fields
//   req_if    in          multiplicand, multiplier, divisor (63 bits each)
//   rsp_if    out         quotient (64 bits), status (2 bits)
//
// One item can enter every cycle while the pipeline is not held. An item
// passes through 130 register stages: four of product and rounding, then 126
// divider stages, one numerator bit per stage. Reset clears every valid bit at
// once; the payload registers are not reset. The whole pipeline advances
// together; when a result waits on rsp_if the pipeline holds, so ready falls
// and no item is lost or repeated.
// ----------------------------------------------------------------------------
module rescale_mul_div_round_unit (
   input  logic          clock,
   input  logic          reset,
   rmd_req_if.sink       req_if,
   rmd_rsp_if.source     rsp_if
);

   localparam int W  = rmd_pkg::OperandWidth;
   localparam int HW = rmd_pkg::HalfWidth;
   localparam int NW = rmd_pkg::NumWidth;

   logic enable;

   // Stage 1: operand registers.
   logic          s1_valid_ff;
   logic [W-1:0]  s1_a_ff, s1_b_ff, s1_c_ff;

   // Stage 2: partial products of the operand halves (32-bit low, 31-bit high).
   logic                s2_valid_ff;
   logic [2*HW-1:0]     s2_p00_ff;
   logic [2*HW-2:0]     s2_p01_ff, s2_p10_ff;
   logic [2*HW-3:0]     s2_p11_ff;
   logic [W-1:0]        s2_c_ff;

   // Stage 3: middle sum and low sum with the rounding half.
   logic                s3_valid_ff;
   logic [2*HW-1:0]     s3_mid_ff;
   logic [2*HW:0]       s3_low_ff;
   logic [2*HW-3:0]     s3_p11_ff;
   logic [W-1:0]        s3_c_ff;

   // Stage 4: full rounded numerator, the first divider input.
   rmd_pkg::div_stage_type s4_ff;
   logic [NW-1:0]          num_in;

   rmd_pkg::div_stage_type chain [rmd_pkg::DivSteps+1];
   rmd_pkg::div_stage_type last;

   // The pipeline moves whenever its last stage is empty or being drained.
   assign enable        = !last.valid || rsp_if.ready;
   assign req_if.ready  = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_if.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ff.valid <= s3_valid_ff;
      end
      if (enable) begin
         s1_a_ff   <= req_if.multiplicand;
         s1_b_ff   <= req_if.multiplier;
         s1_c_ff   <= req_if.divisor;

         s2_p00_ff <= s1_a_ff[HW-1:0] * s1_b_ff[HW-1:0];
         s2_p01_ff <= s1_a_ff[HW-1:0] * s1_b_ff[W-1:HW];
         s2_p10_ff <= s1_a_ff[W-1:HW] * s1_b_ff[HW-1:0];
         s2_p11_ff <= s1_a_ff[W-1:HW] * s1_b_ff[W-1:HW];
         s2_c_ff   <= s1_c_ff;

         s3_mid_ff <= {1'b0, s2_p01_ff} + {1'b0, s2_p10_ff};
         s3_low_ff <= {1'b0, s2_p00_ff} + {{(2*HW+2-W){1'b0}}, s2_c_ff[W-1:1]};
         s3_p11_ff <= s2_p11_ff;
         s3_c_ff   <= s2_c_ff;

         s4_ff.zero    <= (s3_c_ff == '0);
         s4_ff.ovf     <= 1'b0;
         s4_ff.divisor <= s3_c_ff;
         s4_ff.rem     <= '0;
         s4_ff.num     <= num_in;
         s4_ff.quo     <= '0;
      end
   end

   // Product plus half divisor is below 2^126, so the sum fits NumWidth bits.
   always_comb begin
      num_in = {s3_p11_ff, {(2*HW){1'b0}}}
             + {{(NW-3*HW){1'b0}}, s3_mid_ff, {HW{1'b0}}}
             + {{(NW-2*HW-1){1'b0}}, s3_low_ff};
   end

   assign chain[0] = s4_ff;

   for (genvar i = 0; i < rmd_pkg::DivSteps; i++) begin : g_step
      rmd_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign last = chain[rmd_pkg::DivSteps];

   // A zero divisor overrides whatever the divider produced.
   assign rsp_if.valid    = last.valid;
   assign rsp_if.quotient = last.zero ? '0 : last.quo;
   assign rsp_if.status   = last.zero ? rmd_pkg::STATUS_DIV_ZERO :
                            last.ovf  ? rmd_pkg::STATUS_OVERFLOW : rmd_pkg::STATUS_OK;

   // Only the three defined status codes are ever produced.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.status == rmd_pkg::STATUS_OK
                        || rsp_if.status == rmd_pkg::STATUS_DIV_ZERO
                        || rsp_if.status == rmd_pkg::STATUS_OVERFLOW))
      else $error("reserved status code on a result");

   // A zero-divisor result always carries a zero quotient.
   a_zero_quotient: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == rmd_pkg::STATUS_DIV_ZERO) |-> rsp_if.quotient == '0)
      else $error("nonzero quotient on a divide-by-zero result");

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   // A held result keeps its value until it is taken.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> (rsp_if.valid && $stable(rsp_if.quotient)
                                           && $stable(rsp_if.status)))
      else $error("stalled result changed");

endmodule
